// ===== rtl/smtlb_pkg.sv =====
// ----------------------------------------------------------------------------
// smtlb_pkg
// shared types, constants and command codes for the software managed tlb
// ----------------------------------------------------------------------------
package smtlb_pkg;

  localparam int unsigned ENTRIES_DEF       = 32;
  localparam int unsigned FIXED_ENTRIES_DEF = 4;
  localparam int unsigned OFFSET_BITS_DEF   = 12;

  localparam logic [31:0] PRIV_BIT    = 32'h8000_0000;
  localparam logic [31:0] DIRECT_BITS = 32'hC000_0000;

  typedef enum logic [2:0] {
    CMD_TRANSLATE = 3'd0,
    CMD_PROBE     = 3'd1,
    CMD_WRITE_RND = 3'd2,
    CMD_READ_IDX  = 3'd3,
    CMD_WRITE_IDX = 3'd4,
    CMD_REG_WRITE = 3'd5,
    CMD_REG_READ  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_INDEX   = 3'd0,
    SEL_ENTRY_HI = 3'd1,
    SEL_ENTRY_LO = 3'd2,
    SEL_BAD_ADDR = 3'd3,
    SEL_BAD_ACC  = 3'd4
  } sel_t;

  typedef enum logic [2:0] {
    FLT_NONE      = 3'd0,
    FLT_MISALIGN  = 3'd1,
    FLT_PRIV      = 3'd2,
    FLT_MISS      = 3'd3,
    FLT_INVALID   = 3'd4,
    FLT_WPROT     = 3'd5
  } fault_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] virt_addr;
    logic        user_mode;
    logic        is_store;
    logic [1:0]  access_size;
    logic [2:0]  reg_select;
    logic [31:0] reg_wdata;
  } in_item_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic [2:0]  fault;
    logic [31:0] reg_rdata;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

// ===== rtl/smtlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// smtlb_ctrl
// handshake controller: capture, match stage, execute, output hold
// ----------------------------------------------------------------------------
module smtlb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output smtlb_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign take      = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // match results are registered at the end of ST_MATCH, used in ST_EXEC
  assign cmd.capture = take;
  assign cmd.execute = (state_r == ST_EXEC);

endmodule

// ===== rtl/smtlb_dp.sv =====
// ----------------------------------------------------------------------------
// smtlb_dp
// tlb entries, registers, parallel page match and command execution
// ----------------------------------------------------------------------------
module smtlb_dp #(
  parameter int unsigned ENTRIES       = smtlb_pkg::ENTRIES_DEF,
  parameter int unsigned FIXED_ENTRIES = smtlb_pkg::FIXED_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS   = smtlb_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smtlb_pkg::dp_cmd_t   cmd,
  input  smtlb_pkg::in_item_t  in_data,
  output smtlb_pkg::out_item_t out_data
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned PW = 32 - OFFSET_BITS;
  localparam logic [31:0] PG_MASK  = ~((32'd1 << OFFSET_BITS) - 32'd1);
  localparam logic [31:0] IDX_MASK = 32'(ENTRIES - 1);
  localparam logic [IW-1:0] LAST   = IW'(ENTRIES - 1);
  localparam logic [IW-1:0] FIXED  = IW'(FIXED_ENTRIES);

  logic [PW-1:0] page_r  [ENTRIES];
  logic [PW-1:0] frame_r [ENTRIES];
  logic [ENTRIES-1:0] wr_r, vld_r;

  logic [31:0] index_r, hi_r, lo_r, badaddr_r, badacc_r;
  logic [IW-1:0] rptr_r;
  smtlb_pkg::in_item_t item_r;
  smtlb_pkg::out_item_t out_r;

  // match stage registers
  logic          hit_r, hithi_r;
  logic [IW-1:0] hidx_r, hidxhi_r;

  logic [PW-1:0] va_page, hi_page;
  logic          hit_a, hit_b;
  logic [IW-1:0] idx_a, idx_b;

  assign va_page = item_r.virt_addr[31:OFFSET_BITS];
  assign hi_page = hi_r[31:OFFSET_BITS];

  // highest matching index wins
  always_comb begin
    hit_a = 1'b0; idx_a = '0; hit_b = 1'b0; idx_b = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (page_r[i] == va_page) begin hit_a = 1'b1; idx_a = IW'(i); end
      if (page_r[i] == hi_page) begin hit_b = 1'b1; idx_b = IW'(i); end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    hit_r <= hit_a; hidx_r <= idx_a;
    hithi_r <= hit_b; hidxhi_r <= idx_b;
  end

  // execute
  logic [1:0]    size;
  logic          misal, priv_f;
  logic [31:0]   va;
  logic [IW-1:0] slot, wslot;
  logic          do_write;
  smtlb_pkg::out_item_t res;
  logic [31:0]   index_nxt, hi_nxt, lo_nxt, badaddr_nxt, badacc_nxt;
  logic [IW-1:0] rptr_nxt;

  assign va    = item_r.virt_addr;
  assign size  = (item_r.access_size == 2'd3) ? 2'd2 : item_r.access_size;
  assign misal = (size == 2'd2 && va[1:0] != 2'd0) || (size == 2'd1 && va[0]);
  assign priv_f = va[31] && item_r.user_mode;
  assign slot  = index_r[IW-1:0];

  always_comb begin
    res = '0;
    index_nxt = index_r; hi_nxt = hi_r; lo_nxt = lo_r;
    badaddr_nxt = badaddr_r; badacc_nxt = badacc_r; rptr_nxt = rptr_r;
    do_write = 1'b0; wslot = slot;
    unique case (item_r.command)
      smtlb_pkg::CMD_TRANSLATE: begin
        if (misal || priv_f) begin
          res.fault = misal ? smtlb_pkg::FLT_MISALIGN : smtlb_pkg::FLT_PRIV;
          badaddr_nxt = va;
          badacc_nxt = {29'd0, item_r.is_store, size};
        end else begin
          rptr_nxt = (rptr_r <= FIXED) ? LAST : rptr_r - IW'(1);
          if ((va & smtlb_pkg::DIRECT_BITS) == smtlb_pkg::DIRECT_BITS) begin
            res.phys_addr = va & ~smtlb_pkg::DIRECT_BITS;
          end else if (!hit_r || !vld_r[hidx_r] || (!wr_r[hidx_r] && item_r.is_store)) begin
            badaddr_nxt = va;
            badacc_nxt = {29'd0, item_r.is_store, size};
            hi_nxt = va & PG_MASK;
            res.fault = !hit_r ? smtlb_pkg::FLT_MISS :
                        (vld_r[hidx_r] ? smtlb_pkg::FLT_WPROT : smtlb_pkg::FLT_INVALID);
          end else begin
            res.phys_addr = {frame_r[hidx_r], va[OFFSET_BITS-1:0]};
          end
        end
      end
      smtlb_pkg::CMD_PROBE:
        index_nxt = hithi_r ? 32'(hidxhi_r) : smtlb_pkg::PRIV_BIT;
      smtlb_pkg::CMD_WRITE_RND: begin do_write = 1'b1; wslot = rptr_r; end
      smtlb_pkg::CMD_READ_IDX: begin
        hi_nxt = {page_r[slot], OFFSET_BITS'(0)};
        lo_nxt = {frame_r[slot], OFFSET_BITS'(0)} | {30'd0, wr_r[slot], vld_r[slot]};
      end
      smtlb_pkg::CMD_WRITE_IDX: do_write = 1'b1;
      smtlb_pkg::CMD_REG_WRITE: begin
        unique case (item_r.reg_select)
          smtlb_pkg::SEL_INDEX:    index_nxt = item_r.reg_wdata & IDX_MASK;
          smtlb_pkg::SEL_ENTRY_HI: hi_nxt = item_r.reg_wdata & PG_MASK;
          smtlb_pkg::SEL_ENTRY_LO: lo_nxt = item_r.reg_wdata & (PG_MASK | 32'd3);
          smtlb_pkg::SEL_BAD_ADDR: badaddr_nxt = item_r.reg_wdata;
          smtlb_pkg::SEL_BAD_ACC:  badacc_nxt = item_r.reg_wdata;
          default: ;
        endcase
      end
      smtlb_pkg::CMD_REG_READ: begin
        unique case (item_r.reg_select)
          smtlb_pkg::SEL_INDEX:    res.reg_rdata = index_r;
          smtlb_pkg::SEL_ENTRY_HI: res.reg_rdata = hi_r;
          smtlb_pkg::SEL_ENTRY_LO: res.reg_rdata = lo_r;
          smtlb_pkg::SEL_BAD_ADDR: res.reg_rdata = badaddr_r;
          smtlb_pkg::SEL_BAD_ACC:  res.reg_rdata = badacc_r;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0; hi_r <= '0; lo_r <= '0; badaddr_r <= '0; badacc_r <= '0;
      rptr_r <= LAST; wr_r <= '0; vld_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        page_r[i] <= '0; frame_r[i] <= '0;
      end
    end else if (cmd.execute) begin
      index_r <= index_nxt; hi_r <= hi_nxt; lo_r <= lo_nxt;
      badaddr_r <= badaddr_nxt; badacc_r <= badacc_nxt; rptr_r <= rptr_nxt;
      if (do_write) begin
        page_r[wslot]  <= hi_r[31:OFFSET_BITS];
        frame_r[wslot] <= lo_r[31:OFFSET_BITS];
        wr_r[wslot]    <= lo_r[1];
        vld_r[wslot]   <= lo_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) out_r <= res;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/software_managed_tlb_mmu_top.sv =====
// ----------------------------------------------------------------------------
// software_managed_tlb_mmu_top
// fully associative software managed tlb with mmu front end
// ----------------------------------------------------------------------------
// usage
//   in_valid / in_stall / in_data carry one command per transfer: translate,
//   probe, entry write (random or indexed), indexed read, register access
//   out_valid / out_stall / out_data return exactly one result per command
// sequencing
//   a command is captured, its page is matched against all entries in the
//   next cycle (registered compare), then it executes and the result is
//   registered, after which out_valid is raised
//   one command is in flight at a time: a new one is taken only after the
//   capture, match, execute and result transfer steps of the controller
// reset
//   rst_n low clears all entries, valid and writable bits and registers;
//   the replacement pointer starts at the last entry
// stall
//   while out_stall is high the result holds and no new command is taken
// ----------------------------------------------------------------------------
module software_managed_tlb_mmu_top #(
  parameter int unsigned ENTRIES       = smtlb_pkg::ENTRIES_DEF,
  parameter int unsigned FIXED_ENTRIES = smtlb_pkg::FIXED_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS   = smtlb_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  smtlb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smtlb_pkg::out_item_t out_data
);

  // command bundle from controller to datapath
  smtlb_pkg::dp_cmd_t cmd;

  smtlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  smtlb_dp #(
    .ENTRIES       (ENTRIES),
    .FIXED_ENTRIES (FIXED_ENTRIES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== rtl/smtlb_checker.sv =====
// ----------------------------------------------------------------------------
// smtlb_checker
// port level checks for the tlb top level
// ----------------------------------------------------------------------------
module smtlb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input smtlb_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##2 out_valid)
    else $error("result late");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fault <= smtlb_pkg::FLT_WPROT)
    else $error("fault code out of range");

endmodule

bind software_managed_tlb_mmu_top smtlb_checker u_chk (
  .clk (clk), .rst_n (rst_n), .in_valid (in_valid), .in_stall (in_stall),
  .out_valid (out_valid), .out_stall (out_stall), .out_data (out_data)
);
